[design/assert_macros.svh]
// Assertion helper macros for the order queue fill tracker.
// Included by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define POQFT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("poqft: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define POQFT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("poqft: next-cycle check failed");

`endif

[design/poqft_pkg.sv]
// Shared types and constants for the order queue fill tracker.
// No dependencies; used by the controller, the datapath and the top level.
package poqft_pkg;

   // Default table depth and fill limit per trade
   localparam int MAX_ORDERS_DEF = 16;
   localparam int NRES           = 16;
   localparam int NRES_W         = $clog2(NRES);

   // Operation codes
   localparam logic [1:0] OP_PLACE  = 2'd0;
   localparam logic [1:0] OP_TRADE  = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // Result kinds
   localparam logic [2:0] RK_PLACED    = 3'd0;
   localparam logic [2:0] RK_FILL      = 3'd1;
   localparam logic [2:0] RK_NO_FILL   = 3'd2;
   localparam logic [2:0] RK_CANCELLED = 3'd3;
   localparam logic [2:0] RK_FULL      = 3'd4;
   localparam logic [2:0] RK_CLEARED   = 3'd5;

   // Side codes as stored
   localparam logic [1:0] SIDE_BID = 2'b01;
   localparam logic [1:0] SIDE_ASK = 2'b11;

   // Register indexes
   localparam logic [1:0] CSR_LATENCY  = 2'd0;
   localparam logic [1:0] CSR_PRICE_TOL = 2'd1;
   localparam logic [1:0] CSR_QTY_TOL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_APPLY,
      ST_DROP,
      ST_CANCEL
   } state_type;

   typedef struct packed {
      logic place;
      logic clear_all;
      logic ignore;
      logic trade_begin;
      logic cancel_begin;
      logic cnt_clear;
      logic scan;
      logic eval;
      logic apply;
      logic drop;
      logic cancel;
      logic finish_trade;
      logic finish_cancel;
   } cmd_type;

   typedef struct packed {
      logic cmp_last;
      logic best_found;
      logic trade_ignore;
      logic walk_full;
   } status_type;

endpackage

[design/passive_order_queue_fill_tracker_top.sv]
// Top level of the order queue fill tracker: controller plus datapath.
// Depends on poqft_pkg, poqft_ctrl, poqft_dp and assert_macros.svh.
//
//  channel   ports                         handshake
//  request   start, busy, req_*            beat taken when start && !busy
//  result    rsp_valid, rsp_*              one-cycle strobe, no backpressure
//  config    csr_write_enable, csr_*       write taken when enable is high
//
// Place and clear-all complete without raising busy; cancel by id sweeps the table
// once; results follow. A trade that is not ignored scans the whole table once per
// order visited, through the table's single read port, once more to find no order
// left (skipped after 16 fills), then sweeps it to drop filled orders. busy is
// high meanwhile.
// Reset is synchronous and clears the table and the id counter.
`include "assert_macros.svh"

module passive_order_queue_fill_tracker_top #(
   parameter int MAX_ORDERS = poqft_pkg::MAX_ORDERS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic signed [1:0]  req_order_side,
   input  logic signed [1:0]  req_taker_side,
   input  logic [31:0]        req_price_ticks,
   input  logic [31:0]        req_quantity,
   input  logic [31:0]        req_queue_ahead,
   input  logic [47:0]        req_timestamp_ms,
   input  logic [31:0]        req_order_id,
   output logic               rsp_valid,
   output logic [2:0]         rsp_result_kind,
   output logic [31:0]        rsp_assigned_id,
   output logic [31:0]        rsp_fill_price,
   output logic [31:0]        rsp_fill_qty,
   output logic signed [1:0]  rsp_fill_side,
   output logic [47:0]        rsp_trade_time_ms,
   output logic [47:0]        rsp_placed_time_ms,
   output logic               rsp_swept,
   output logic               rsp_last_result,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   poqft_pkg::cmd_type    cmd;
   poqft_pkg::status_type status;

   logic place_beat;
   logic last_beat;
   logic nonfill_beat;

   poqft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_operation),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   poqft_dp #(
      .MAX_ORDERS (MAX_ORDERS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_order_side     (req_order_side),
      .req_taker_side     (req_taker_side),
      .req_price_ticks    (req_price_ticks),
      .req_quantity       (req_quantity),
      .req_queue_ahead    (req_queue_ahead),
      .req_timestamp_ms   (req_timestamp_ms),
      .req_order_id       (req_order_id),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_assigned_id    (rsp_assigned_id),
      .rsp_fill_price     (rsp_fill_price),
      .rsp_fill_qty       (rsp_fill_qty),
      .rsp_fill_side      (rsp_fill_side),
      .rsp_trade_time_ms  (rsp_trade_time_ms),
      .rsp_placed_time_ms (rsp_placed_time_ms),
      .rsp_swept          (rsp_swept),
      .rsp_last_result    (rsp_last_result)
   );

   // terms for the checks below
   assign place_beat   = start && !busy && (req_operation == poqft_pkg::OP_PLACE);
   assign last_beat    = rsp_valid && rsp_last_result;
   assign nonfill_beat = rsp_valid && (rsp_result_kind != poqft_pkg::RK_FILL);

   // a place always answers in the next cycle with a single final beat
   `POQFT_ASSERT_NEXT(a_place_answers, clock, reset, place_beat, last_beat)

   // only fill beats may be followed by more beats of the same item
   `POQFT_ASSERT_IMP(a_nonfill_is_last, clock, reset, nonfill_beat, rsp_last_result)

   // the end of a multi-cycle item always shows its final beat
   `POQFT_ASSERT_IMP(a_done_has_last, clock, reset, $fell(busy), last_beat)

endmodule

[design/poqft_ctrl.sv]
// Controller state machine for the order queue fill tracker.
// Depends on poqft_pkg; drives commands to poqft_dp and reads its status.
module poqft_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             operation,
   input  poqft_pkg::status_type  status,
   output poqft_pkg::cmd_type     cmd,
   output logic                   busy
);

   poqft_pkg::state_type state_ff;
   poqft_pkg::state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= poqft_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         poqft_pkg::ST_IDLE: begin
            if (start) begin
               unique case (operation)
                  poqft_pkg::OP_TRADE: begin
                     if (!status.trade_ignore) state_in = poqft_pkg::ST_SCAN;
                  end
                  poqft_pkg::OP_CANCEL: state_in = poqft_pkg::ST_CANCEL;
                  poqft_pkg::OP_PLACE,
                  poqft_pkg::OP_CLEAR: state_in = poqft_pkg::ST_IDLE;
               endcase
            end
         end
         poqft_pkg::ST_SCAN: begin
            if (status.cmp_last) state_in = poqft_pkg::ST_EVAL;
         end
         poqft_pkg::ST_EVAL: begin
            state_in = status.best_found ? poqft_pkg::ST_APPLY : poqft_pkg::ST_DROP;
         end
         poqft_pkg::ST_APPLY: begin
            state_in = status.walk_full ? poqft_pkg::ST_DROP : poqft_pkg::ST_SCAN;
         end
         poqft_pkg::ST_DROP,
         poqft_pkg::ST_CANCEL: begin
            if (status.cmp_last) state_in = poqft_pkg::ST_IDLE;
         end
         default: state_in = poqft_pkg::ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         poqft_pkg::ST_IDLE: begin
            if (start) begin
               unique case (operation)
                  poqft_pkg::OP_PLACE: cmd.place = 1'b1;
                  poqft_pkg::OP_TRADE: begin
                     if (status.trade_ignore) begin
                        cmd.ignore = 1'b1;
                     end else begin
                        cmd.trade_begin = 1'b1;
                        cmd.cnt_clear   = 1'b1;
                     end
                  end
                  poqft_pkg::OP_CANCEL: begin
                     cmd.cancel_begin = 1'b1;
                     cmd.cnt_clear    = 1'b1;
                  end
                  poqft_pkg::OP_CLEAR: cmd.clear_all = 1'b1;
               endcase
            end
         end
         poqft_pkg::ST_SCAN: cmd.scan = 1'b1;
         poqft_pkg::ST_EVAL: begin
            cmd.eval      = 1'b1;
            cmd.cnt_clear = !status.best_found;
         end
         poqft_pkg::ST_APPLY: begin
            cmd.apply     = 1'b1;
            cmd.cnt_clear = 1'b1;
         end
         poqft_pkg::ST_DROP: begin
            cmd.drop         = 1'b1;
            cmd.finish_trade = status.cmp_last;
         end
         poqft_pkg::ST_CANCEL: begin
            cmd.cancel        = 1'b1;
            cmd.finish_cancel = status.cmp_last;
         end
         default: cmd = '0;
      endcase
   end

   assign busy = (state_ff != poqft_pkg::ST_IDLE);

endmodule

[design/poqft_dp.sv]
// Datapath for the order queue fill tracker: order table, scan pipeline,
// fill arithmetic, result register. Depends on poqft_pkg; driven by poqft_ctrl.
module poqft_dp #(
   parameter int MAX_ORDERS = poqft_pkg::MAX_ORDERS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  poqft_pkg::cmd_type     cmd,
   output poqft_pkg::status_type  status,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_write_data,
   input  logic signed [1:0]      req_order_side,
   input  logic signed [1:0]      req_taker_side,
   input  logic [31:0]            req_price_ticks,
   input  logic [31:0]            req_quantity,
   input  logic [31:0]            req_queue_ahead,
   input  logic [47:0]            req_timestamp_ms,
   input  logic [31:0]            req_order_id,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_result_kind,
   output logic [31:0]            rsp_assigned_id,
   output logic [31:0]            rsp_fill_price,
   output logic [31:0]            rsp_fill_qty,
   output logic signed [1:0]      rsp_fill_side,
   output logic [47:0]            rsp_trade_time_ms,
   output logic [47:0]            rsp_placed_time_ms,
   output logic                   rsp_swept,
   output logic                   rsp_last_result
);

   localparam int IDX_W = $clog2(MAX_ORDERS);
   localparam int CNT_W = $clog2(MAX_ORDERS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ORDERS - 1);

   // configuration registers
   logic [15:0] lat_ff;
   logic [7:0]  ptol_ff;
   logic [15:0] qtol_ff;
   logic [31:0] qtol32;

   // table storage
   logic [MAX_ORDERS-1:0] valid_ff;
   logic [MAX_ORDERS-1:0] visited_ff;
   logic [1:0]  side_mem  [MAX_ORDERS];
   logic [31:0] price_mem [MAX_ORDERS];
   logic [31:0] own_mem   [MAX_ORDERS];
   logic [31:0] qa_mem    [MAX_ORDERS];
   logic [47:0] ptime_mem [MAX_ORDERS];
   logic [31:0] id_mem    [MAX_ORDERS];
   logic [31:0] next_id_ff;

   // read port
   logic [IDX_W-1:0] rd_addr;
   logic [1:0]  rd_side_ff;
   logic [31:0] rd_price_ff;
   logic [31:0] rd_own_ff;
   logic [31:0] rd_qa_ff;
   logic [47:0] rd_ptime_ff;
   logic [31:0] rd_id_ff;

   // sweep counter
   logic [CNT_W-1:0] cnt_ff;
   logic [IDX_W-1:0] idx_d_ff;
   logic             cmp_v_ff;
   logic             sweeping;

   // trade and cancel operands
   logic [31:0] tp_ff;
   logic [31:0] rem_ff;
   logic [47:0] ts_ff;
   logic [1:0]  target_ff;
   logic [31:0] cancel_id_ff;
   logic        bid;

   // best candidate of the current scan
   logic             best_found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [31:0]      best_price_ff;
   logic [31:0]      best_id_ff;
   logic [31:0]      best_own_ff;
   logic [31:0]      best_qa_ff;
   logic [47:0]      best_ptime_ff;
   logic [1:0]       best_side_ff;

   // evaluation results
   logic        go_ff;
   logic        fill_ok_ff;
   logic        sw_ff;
   logic [31:0] qa_new_ff;

   // fill count and pending fill
   logic [poqft_pkg::NRES_W-1:0] n_ff;
   logic        pend_v_ff;
   logic [31:0] pend_price_ff;
   logic [31:0] pend_qty_ff;
   logic [1:0]  pend_side_ff;
   logic [47:0] pend_ptime_ff;
   logic        pend_sw_ff;

   // free slot search
   logic [IDX_W-1:0] slot;
   logic             full;

   // combinational terms
   logic        trade_ignore;
   logic        cand;
   logic        better;
   logic        take;
   logic [48:0] rest_sum;
   logic        rested;
   logic [31:0] diff;
   logic        at_level;
   logic        not_reached;
   logic [31:0] dq;
   logic [31:0] qa_after;
   logic [31:0] rem_after;
   logic        fill_ok;
   logic [31:0] fq;
   logic        emit;

   // result register next values
   logic        out_v_in;
   logic [2:0]  out_kind_in;
   logic [31:0] out_id_in;
   logic [31:0] out_price_in;
   logic [31:0] out_qty_in;
   logic [1:0]  out_side_in;
   logic [47:0] out_tt_in;
   logic [47:0] out_pt_in;
   logic        out_sw_in;
   logic        out_last_in;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_kind_ff;
   logic [31:0] rsp_id_ff;
   logic [31:0] rsp_price_ff;
   logic [31:0] rsp_qty_ff;
   logic [1:0]  rsp_side_ff;
   logic [47:0] rsp_tt_ff;
   logic [47:0] rsp_pt_ff;
   logic        rsp_sw_ff;
   logic        rsp_last_ff;

   assign qtol32 = {16'd0, qtol_ff};
   assign bid    = (target_ff == poqft_pkg::SIDE_BID);

   // write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff  <= '0;
         ptol_ff <= '0;
         qtol_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            poqft_pkg::CSR_LATENCY:   lat_ff  <= csr_write_data;
            poqft_pkg::CSR_PRICE_TOL: ptol_ff <= csr_write_data[7:0];
            poqft_pkg::CSR_QTY_TOL:   qtol_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // pick lowest free slot
   always_comb begin
      slot = '0;
      for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) slot = IDX_W'(i);
      end
   end
   assign full = &valid_ff;

   assign trade_ignore = (req_quantity <= qtol32) ||
                         !(req_taker_side == 2'sb01 || req_taker_side == 2'sb11);

   // sweep counter and read pipeline
   assign sweeping = cmd.scan || cmd.drop || cmd.cancel;
   assign rd_addr  = cnt_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         cmp_v_ff <= 1'b0;
      end else if (cmd.cnt_clear) begin
         cnt_ff   <= '0;
         cmp_v_ff <= 1'b0;
      end else if (sweeping && cnt_ff < CNT_W'(MAX_ORDERS)) begin
         cnt_ff   <= cnt_ff + CNT_W'(1);
         cmp_v_ff <= 1'b1;
      end else begin
         cmp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      idx_d_ff    <= rd_addr;
      rd_side_ff  <= side_mem[rd_addr];
      rd_price_ff <= price_mem[rd_addr];
      rd_own_ff   <= own_mem[rd_addr];
      rd_qa_ff    <= qa_mem[rd_addr];
      rd_ptime_ff <= ptime_mem[rd_addr];
      rd_id_ff    <= id_mem[rd_addr];
   end

   // write the table
   always_ff @(posedge clock) begin
      if (cmd.place && !full) begin
         side_mem[slot]  <= req_order_side;
         price_mem[slot] <= req_price_ticks;
         own_mem[slot]   <= req_quantity;
         qa_mem[slot]    <= req_queue_ahead;
         ptime_mem[slot] <= req_timestamp_ms;
         id_mem[slot]    <= next_id_ff;
      end else if (cmd.apply) begin
         if (go_ff) qa_mem[best_idx_ff] <= qa_new_ff;
         if (emit)  own_mem[best_idx_ff] <= best_own_ff - fq;
      end
   end

   // scan compare: price priority, lower id on ties
   assign cand = valid_ff[idx_d_ff] && !visited_ff[idx_d_ff] && (rd_side_ff == target_ff);
   always_comb begin
      if (!best_found_ff) begin
         better = 1'b1;
      end else if (rd_price_ff != best_price_ff) begin
         better = bid ? (rd_price_ff > best_price_ff) : (rd_price_ff < best_price_ff);
      end else begin
         better = (rd_id_ff < best_id_ff);
      end
   end
   assign take = cmd.scan && cmp_v_ff && cand && better;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else if (cmd.cnt_clear) begin
         best_found_ff <= 1'b0;
      end else if (take) begin
         best_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff   <= idx_d_ff;
         best_price_ff <= rd_price_ff;
         best_id_ff    <= rd_id_ff;
         best_own_ff   <= rd_own_ff;
         best_qa_ff    <= rd_qa_ff;
         best_ptime_ff <= rd_ptime_ff;
         best_side_ff  <= rd_side_ff;
      end
   end

   // evaluate the chosen order: latency, level, queue ahead
   assign rest_sum    = {1'b0, best_ptime_ff} + {33'd0, lat_ff};
   assign rested      = ({1'b0, ts_ff} >= rest_sum);
   assign diff        = (tp_ff >= best_price_ff) ? (tp_ff - best_price_ff)
                                                 : (best_price_ff - tp_ff);
   assign at_level    = (diff <= {24'd0, ptol_ff});
   assign not_reached = bid ? (tp_ff > best_price_ff) : (tp_ff < best_price_ff);
   assign dq          = (best_qa_ff < rem_ff) ? best_qa_ff : rem_ff;
   assign qa_after    = at_level ? (best_qa_ff - dq) : 32'd0;
   assign rem_after   = at_level ? (rem_ff - dq) : rem_ff;
   assign fill_ok     = !at_level || ((rem_after > qtol32) && (qa_after <= qtol32));

   // fill amount for the apply step
   assign fq   = (best_own_ff < rem_ff) ? best_own_ff : rem_ff;
   assign emit = cmd.apply && go_ff && fill_ok_ff && (fq > qtol32);

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         go_ff      <= rested && (at_level || !not_reached);
         fill_ok_ff <= fill_ok;
         sw_ff      <= !at_level;
         qa_new_ff  <= qa_after;
      end
   end

   // trade operands and remaining budget
   always_ff @(posedge clock) begin
      if (cmd.trade_begin) begin
         tp_ff     <= req_price_ticks;
         rem_ff    <= req_quantity;
         ts_ff     <= req_timestamp_ms;
         target_ff <= (req_taker_side == 2'sb01) ? poqft_pkg::SIDE_ASK : poqft_pkg::SIDE_BID;
      end else if (cmd.eval && rested && (at_level || !not_reached)) begin
         rem_ff <= rem_after;
      end else if (emit) begin
         rem_ff <= rem_ff - fq;
      end
      if (cmd.cancel_begin) cancel_id_ff <= req_order_id;
   end

   // valid and visited bits, next id
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         next_id_ff <= '0;
      end else begin
         if (cmd.clear_all) begin
            valid_ff <= '0;
         end else if (cmd.place && !full) begin
            valid_ff[slot] <= 1'b1;
            next_id_ff     <= next_id_ff + 32'd1;
         end else if (cmp_v_ff && cmd.drop && (rd_own_ff <= qtol32)) begin
            valid_ff[idx_d_ff] <= 1'b0;
         end else if (cmp_v_ff && cmd.cancel && (rd_id_ff == cancel_id_ff)) begin
            valid_ff[idx_d_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trade_begin) begin
         visited_ff <= '0;
      end else if (cmd.eval && best_found_ff) begin
         visited_ff[best_idx_ff] <= 1'b1;
      end
   end

   // fill count and pending fill; a fill leaves only when the next one or the end is known
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
      end else if (cmd.trade_begin) begin
         pend_v_ff <= 1'b0;
      end else if (emit) begin
         pend_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trade_begin) begin
         n_ff <= '0;
      end else if (emit) begin
         n_ff <= n_ff + poqft_pkg::NRES_W'(1);
      end
      if (emit) begin
         pend_price_ff <= best_price_ff;
         pend_qty_ff   <= fq;
         pend_side_ff  <= best_side_ff;
         pend_ptime_ff <= best_ptime_ff;
         pend_sw_ff    <= sw_ff;
      end
   end

   // build the next result beat
   always_comb begin
      out_v_in     = 1'b0;
      out_kind_in  = poqft_pkg::RK_NO_FILL;
      out_id_in    = '0;
      out_price_in = '0;
      out_qty_in   = '0;
      out_side_in  = '0;
      out_tt_in    = '0;
      out_pt_in    = '0;
      out_sw_in    = 1'b0;
      out_last_in  = 1'b1;
      priority if (cmd.place) begin
         out_v_in    = 1'b1;
         out_kind_in = full ? poqft_pkg::RK_FULL : poqft_pkg::RK_PLACED;
         out_id_in   = full ? 32'd0 : next_id_ff;
      end else if (cmd.ignore) begin
         out_v_in = 1'b1;
      end else if (cmd.clear_all) begin
         out_v_in    = 1'b1;
         out_kind_in = poqft_pkg::RK_CLEARED;
      end else if (cmd.finish_cancel) begin
         out_v_in    = 1'b1;
         out_kind_in = poqft_pkg::RK_CANCELLED;
      end else if ((emit || cmd.finish_trade) && pend_v_ff) begin
         out_v_in     = 1'b1;
         out_kind_in  = poqft_pkg::RK_FILL;
         out_price_in = pend_price_ff;
         out_qty_in   = pend_qty_ff;
         out_side_in  = pend_side_ff;
         out_tt_in    = ts_ff;
         out_pt_in    = pend_ptime_ff;
         out_sw_in    = pend_sw_ff;
         out_last_in  = cmd.finish_trade;
      end else if (cmd.finish_trade) begin
         out_v_in = 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_v_in) begin
         rsp_kind_ff  <= out_kind_in;
         rsp_id_ff    <= out_id_in;
         rsp_price_ff <= out_price_in;
         rsp_qty_ff   <= out_qty_in;
         rsp_side_ff  <= out_side_in;
         rsp_tt_ff    <= out_tt_in;
         rsp_pt_ff    <= out_pt_in;
         rsp_sw_ff    <= out_sw_in;
         rsp_last_ff  <= out_last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_assigned_id    = rsp_id_ff;
   assign rsp_fill_price     = rsp_price_ff;
   assign rsp_fill_qty       = rsp_qty_ff;
   assign rsp_fill_side      = rsp_side_ff;
   assign rsp_trade_time_ms  = rsp_tt_ff;
   assign rsp_placed_time_ms = rsp_pt_ff;
   assign rsp_swept          = rsp_sw_ff;
   assign rsp_last_result    = rsp_last_ff;

   // status to the controller
   assign status.cmp_last     = cmp_v_ff && (idx_d_ff == LAST_IDX);
   assign status.best_found   = best_found_ff;
   assign status.trade_ignore = trade_ignore;
   assign status.walk_full    = emit && (n_ff == poqft_pkg::NRES_W'(poqft_pkg::NRES - 1));

endmodule

[dv/testbench.sv]
// Self-checking testbench for passive_order_queue_fill_tracker_top.
// Depends on poqft_pkg and the block's RTL. A scoreboard class predicts every
// result beat from the accepted request beats and checks them in order.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN       = 2 * (DEPTH + 3) * (DEPTH + 1);

   // side codes outside the bid and ask pair
   localparam logic [1:0] SIDE_NONE = 2'b00;
   localparam logic [1:0] SIDE_ODD  = 2'b10;

   typedef struct {
      logic [1:0]  op;
      logic [1:0]  oside;
      logic [1:0]  tside;
      logic [31:0] price;
      logic [31:0] qty;
      logic [31:0] qahead;
      logic [47:0] ts;
      logic [31:0] oid;
   } req_beat_type;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] id;
      logic [31:0] price;
      logic [31:0] qty;
      logic [1:0]  side;
      logic [47:0] tt;
      logic [47:0] pt;
      logic        sw;
      logic        last;
   } fill_beat_type;

   // Order book mirror: predicts result beats and checks them in arrival order
   class fill_book_scoreboard;
      bit            vld[DEPTH];
      logic [1:0]    side[DEPTH];
      logic [31:0]   px[DEPTH];
      logic [31:0]   own[DEPTH];
      logic [31:0]   qa[DEPTH];
      logic [47:0]   pt[DEPTH];
      logic [31:0]   oid[DEPTH];
      logic [31:0]   next_id = '0;
      logic [15:0]   lat = '0;
      logic [7:0]    ptol = '0;
      logic [15:0]   qtol = '0;
      fill_beat_type pending[$];
      int            errors;
      int            fills;
      int            checked;

      function void push_beat(logic [2:0] kind, logic [31:0] id = 0,
                              logic [31:0] price = 0, logic [31:0] qty = 0,
                              logic [1:0] sd = 0, logic [47:0] tt = 0,
                              logic [47:0] ptm = 0, logic sw = 0);
         fill_beat_type b;
         b = '{kind, id, price, qty, sd, tt, ptm, sw, 1'b0};
         pending = {pending, b};
      endfunction

      // True if entry a is walked before entry b
      function bit ahead_of(int a, int b, bit bid);
         if (px[a] != px[b]) return bid ? (px[a] > px[b]) : (px[a] < px[b]);
         return oid[a] < oid[b];
      endfunction

      function void walk_trade(req_beat_type r);
         logic [31:0] rem, d, f, diff;
         bit          vis[DEPTH];
         int          best, n;
         logic [1:0]  tgt;
         bit          bid, at, sw;
         rem = r.qty;
         n = 0;
         if (rem <= qtol ||
             (r.tside != poqft_pkg::SIDE_BID && r.tside != poqft_pkg::SIDE_ASK)) begin
            push_beat(poqft_pkg::RK_NO_FILL);
            return;
         end
         tgt = (r.tside == poqft_pkg::SIDE_BID) ? poqft_pkg::SIDE_ASK : poqft_pkg::SIDE_BID;
         bid = (tgt == poqft_pkg::SIDE_BID);
         foreach (vis[i]) vis[i] = 0;
         while (n < poqft_pkg::NRES) begin
            best = -1;
            for (int i = 0; i < DEPTH; i++)
               if (vld[i] && !vis[i] && side[i] == tgt)
                  if (best < 0 || ahead_of(i, best, bid)) best = i;
            if (best < 0) break;
            vis[best] = 1;
            // skip orders still inside the latency window
            if (49'(r.ts) < 49'(pt[best]) + 49'(lat)) continue;
            diff = (r.price >= px[best]) ? r.price - px[best] : px[best] - r.price;
            at = (diff <= ptol);
            if (!at && (bid ? (r.price > px[best]) : (r.price < px[best]))) continue;
            sw = !at;
            if (sw) begin
               qa[best] = 0;
            end else begin
               d = (qa[best] < rem) ? qa[best] : rem;
               qa[best] -= d;
               rem -= d;
               if (!(rem > qtol && qa[best] <= qtol)) continue;
            end
            f = (own[best] < rem) ? own[best] : rem;
            if (f > qtol) begin
               push_beat(poqft_pkg::RK_FILL, 0, px[best], f, side[best], r.ts, pt[best], sw);
               n++;
               fills++;
               own[best] -= f;
               rem -= f;
            end
         end
         // drop fully filled orders
         for (int i = 0; i < DEPTH; i++)
            if (vld[i] && own[i] <= qtol) vld[i] = 0;
         if (n == 0) push_beat(poqft_pkg::RK_NO_FILL);
      endfunction

      function void note_request(req_beat_type r);
         int slot;
         case (r.op)
            poqft_pkg::OP_PLACE: begin
               slot = -1;
               for (int i = DEPTH - 1; i >= 0; i--) if (!vld[i]) slot = i;
               if (slot < 0) begin
                  push_beat(poqft_pkg::RK_FULL);
               end else begin
                  vld[slot] = 1;
                  side[slot] = r.oside;
                  px[slot] = r.price;
                  own[slot] = r.qty;
                  qa[slot] = r.qahead;
                  pt[slot] = r.ts;
                  oid[slot] = next_id;
                  push_beat(poqft_pkg::RK_PLACED, next_id);
                  next_id++;
               end
            end
            poqft_pkg::OP_TRADE: walk_trade(r);
            poqft_pkg::OP_CANCEL: begin
               for (int i = 0; i < DEPTH; i++)
                  if (vld[i] && oid[i] == r.oid) vld[i] = 0;
               push_beat(poqft_pkg::RK_CANCELLED);
            end
            default: begin
               foreach (vld[i]) vld[i] = 0;
               push_beat(poqft_pkg::RK_CLEARED);
            end
         endcase
         pending[pending.size() - 1].last = 1'b1;
      endfunction

      function void report(string fld, logic [63:0] e, logic [63:0] a);
         $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, fld, e, a);
         errors++;
      endfunction

      function void check_result(fill_beat_type a);
         fill_beat_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat, kind %0d", $time, a.kind);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (e.kind  !== a.kind)  report("result_kind", 64'(e.kind), 64'(a.kind));
         if (e.id    !== a.id)    report("assigned_id", 64'(e.id), 64'(a.id));
         if (e.price !== a.price) report("fill_price", 64'(e.price), 64'(a.price));
         if (e.qty   !== a.qty)   report("fill_qty", 64'(e.qty), 64'(a.qty));
         if (e.side  !== a.side)  report("fill_side", 64'(e.side), 64'(a.side));
         if (e.tt    !== a.tt)    report("trade_time_ms", 64'(e.tt), 64'(a.tt));
         if (e.pt    !== a.pt)    report("placed_time_ms", 64'(e.pt), 64'(a.pt));
         if (e.sw    !== a.sw)    report("swept", 64'(e.sw), 64'(a.sw));
         if (e.last  !== a.last)  report("last_result", 64'(e.last), 64'(a.last));
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [1:0]         req_operation = '0;
   logic signed [1:0]  req_order_side = '0;
   logic signed [1:0]  req_taker_side = '0;
   logic [31:0]        req_price_ticks = '0;
   logic [31:0]        req_quantity = '0;
   logic [31:0]        req_queue_ahead = '0;
   logic [47:0]        req_timestamp_ms = '0;
   logic [31:0]        req_order_id = '0;
   logic               rsp_valid;
   logic [2:0]         rsp_result_kind;
   logic [31:0]        rsp_assigned_id;
   logic [31:0]        rsp_fill_price;
   logic [31:0]        rsp_fill_qty;
   logic signed [1:0]  rsp_fill_side;
   logic [47:0]        rsp_trade_time_ms;
   logic [47:0]        rsp_placed_time_ms;
   logic               rsp_swept;
   logic               rsp_last_result;
   logic               csr_write_enable = 0;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_write_data = '0;

   fill_book_scoreboard book = new();
   int          cycles = 0;
   int          items = 0;
   int          burst_left = 0;
   int          cfg_writes = 0;
   logic [47:0] now_ms = 48'd1000;
   logic [31:0] mid_px = 32'd5000;

   passive_order_queue_fill_tracker_top #(.MAX_ORDERS(DEPTH)) i_dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Check every result beat as it is strobed
   always @(posedge clock) begin
      fill_beat_type a;
      if (!reset && rsp_valid) begin
         a = '{rsp_result_kind, rsp_assigned_id, rsp_fill_price, rsp_fill_qty,
               rsp_fill_side, rsp_trade_time_ms, rsp_placed_time_ms, rsp_swept,
               rsp_last_result};
         book.check_result(a);
      end
   end

   // Drive one request beat, with bursts and random gaps between them
   task automatic send_beat(req_beat_type r);
      if (burst_left == 0) begin
         @(negedge clock);
         start = 0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 4))
            @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end else begin
         @(negedge clock);
      end
      burst_left--;
      start = 1;
      req_operation = r.op;
      req_order_side = r.oside;
      req_taker_side = r.tside;
      req_price_ticks = r.price;
      req_quantity = r.qty;
      req_queue_ahead = r.qahead;
      req_timestamp_ms = r.ts;
      req_order_id = r.oid;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      book.note_request(r);
      items++;
   endtask

   task automatic settle_idle();
      @(negedge clock);
      start = 0;
      while (book.pending.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = val;
      @(negedge clock);
      csr_write_enable = 0;
      case (idx)
         poqft_pkg::CSR_LATENCY:   book.lat = val;
         poqft_pkg::CSR_PRICE_TOL: book.ptol = val[7:0];
         default:                  book.qtol = val;
      endcase
      cfg_writes++;
   endtask

   task automatic set_config(logic [15:0] lat, logic [15:0] ptol, logic [15:0] qtol);
      settle_idle();
      write_csr(poqft_pkg::CSR_LATENCY, lat);
      write_csr(poqft_pkg::CSR_PRICE_TOL, ptol);
      write_csr(poqft_pkg::CSR_QTY_TOL, qtol);
   endtask

   function automatic req_beat_type make_beat(logic [1:0] op, logic [1:0] sd,
                                              logic [31:0] price, logic [31:0] qty,
                                              logic [31:0] qahead, logic [47:0] ts,
                                              logic [31:0] id = 0);
      req_beat_type r;
      r = '{op, sd, sd, price, qty, qahead, ts, id};
      return r;
   endfunction

   function automatic logic [1:0] pick_side();
      case ($urandom_range(0, 19))
         0:       return SIDE_NONE;
         1:       return SIDE_ODD;
         default: return $urandom_range(0, 1) ? poqft_pkg::SIDE_BID : poqft_pkg::SIDE_ASK;
      endcase
   endfunction

   function automatic logic [31:0] pick_qty(int hi);
      if ($urandom_range(0, 15) == 0) return $urandom;
      return book.qtol + $urandom_range(0, hi);
   endfunction

   // Random order flow around a drifting mid price and clock
   function automatic req_beat_type random_beat();
      req_beat_type r;
      int           roll;
      roll = $urandom_range(0, 99);
      now_ms += 48'($urandom_range(0, 600));
      if ($urandom_range(0, 60) == 0) now_ms = 48'({$urandom, $urandom} >> 16);
      if ($urandom_range(0, 80) == 0) mid_px = $urandom;
      r.oside = pick_side();
      r.tside = pick_side();
      r.price = mid_px + $urandom_range(0, 40) - 20;
      if ($urandom_range(0, 30) == 0) r.price = $urandom;
      r.qahead = ($urandom_range(0, 10) == 0) ? $urandom : $urandom_range(0, 800);
      r.ts = now_ms;
      r.oid = ($urandom_range(0, 5) == 0) ? $urandom : book.next_id - $urandom_range(1, 24);
      if (roll < 48) begin
         r.op = poqft_pkg::OP_PLACE;
         r.qty = pick_qty(500);
      end else if (roll < 86) begin
         r.op = poqft_pkg::OP_TRADE;
         r.qty = pick_qty(3000);
      end else if (roll < 97) begin
         r.op = poqft_pkg::OP_CANCEL;
         r.qty = $urandom;
      end else begin
         r.op = poqft_pkg::OP_CLEAR;
         r.qty = $urandom;
      end
      return r;
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: fill the table at the field extremes, overflow, sweep, cancels
      for (int i = 0; i < DEPTH; i++)
         send_beat(make_beat(poqft_pkg::OP_PLACE,
                             (i % 2) ? poqft_pkg::SIDE_ASK : poqft_pkg::SIDE_BID,
                             (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'd0 : 32'd100 + i,
                             (i < 2) ? 32'hFFFF_FFFF : 32'd10,
                             (i == 2) ? 32'hFFFF_FFFF : 32'd5,
                             (i == 3) ? 48'hFFFF_FFFF_FFFF : 48'd0));
      send_beat(make_beat(poqft_pkg::OP_PLACE, poqft_pkg::SIDE_BID, 32'd1, 32'd1, 32'd0,
                          48'd1));
      send_beat(make_beat(poqft_pkg::OP_TRADE, poqft_pkg::SIDE_ASK, 32'd0, 32'hFFFF_FFFF,
                          32'd0, 48'd50));
      send_beat(make_beat(poqft_pkg::OP_TRADE, poqft_pkg::SIDE_BID, 32'hFFFF_FFFF, 32'd40,
                          32'd0, 48'd50));
      send_beat(make_beat(poqft_pkg::OP_TRADE, SIDE_NONE, 32'd100, 32'd40, 32'd0, 48'd50));
      send_beat(make_beat(poqft_pkg::OP_TRADE, SIDE_ODD, 32'd100, 32'd40, 32'd0, 48'd50));
      send_beat(make_beat(poqft_pkg::OP_TRADE, poqft_pkg::SIDE_BID, 32'd100, 32'd0, 32'd0,
                          48'd50));
      send_beat(make_beat(poqft_pkg::OP_CANCEL, poqft_pkg::SIDE_BID, 32'd0, 32'd0, 32'd0,
                          48'd0, 32'd3));
      send_beat(make_beat(poqft_pkg::OP_CANCEL, poqft_pkg::SIDE_BID, 32'd0, 32'd0, 32'd0,
                          48'd0, 32'hFFFF_FFFF));
      send_beat(make_beat(poqft_pkg::OP_CLEAR, poqft_pkg::SIDE_BID, 32'd0, 32'd0, 32'd0,
                          48'd0));

      // Random phases across register settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_config(16'd0, 16'd0, 16'd0);
            1: set_config(16'd50, 16'd2, 16'd3);
            2: set_config(16'hFFFF, 16'd255, 16'hFFFF);
            3: set_config(16'd0, 16'd255, 16'd0);
            4: set_config(16'($urandom), 16'($urandom_range(0, 10)),
                          16'($urandom_range(0, 40)));
            default: set_config(16'd1, 16'd0, 16'd1);
         endcase
         if (ph == 2) mid_px = 32'd5000;
         repeat (76) send_beat(random_beat());
      end

      settle_idle();
      $display("testbench: %0d requests, %0d result beats checked, %0d fills, %0d csr writes",
               items, book.checked, book.fills, cfg_writes);
      if (book.errors == 0 && book.pending.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: %0d mismatches, %0d beats outstanding", book.errors,
                  book.pending.size());
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule

[passive_order_queue_fill_tracker_top.f]
+incdir+design
design/poqft_pkg.sv
design/poqft_ctrl.sv
design/poqft_dp.sv
design/passive_order_queue_fill_tracker_top.sv
dv/testbench.sv
